// File: hw/rtl/ppq_pkg.sv
// ----------------------------------------------------------------------------
// ppq_pkg: shared types and constants for the pending request queue
// Field widths, command codes and the request/result structs.
// ----------------------------------------------------------------------------
package ppq_pkg;
	localparam int DEPTH   = 16;
	localparam int IDX_W   = 4;
	localparam int LEN_W   = 5;
	localparam int TAG_W   = 16;
	localparam int CODE_W  = 16;
	localparam int TMO_W   = 16;
	localparam int TIME_W  = 32;
	localparam int QDEPTH  = 2;

	localparam logic [3:0] CMD_PUSH     = 4'd0;
	localparam logic [3:0] CMD_POP_HEAD = 4'd1;
	localparam logic [3:0] CMD_POP_TAG  = 4'd2;
	localparam logic [3:0] CMD_FIND_TAG = 4'd3;
	localparam logic [3:0] CMD_FIND_CMD = 4'd4;
	localparam logic [3:0] CMD_NEXT     = 4'd5;
	localparam logic [3:0] CMD_MARK     = 4'd6;
	localparam logic [3:0] CMD_TIMEOUT  = 4'd7;
	localparam logic [3:0] CMD_CANCEL   = 4'd8;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [1:0] PRI_IMM  = 2'd0;
	localparam logic [1:0] PRI_HIGH = 2'd1;

	localparam logic [1:0] FILT_WAIT = 2'd1;
	localparam logic [1:0] FILT_SENT = 2'd2;

	typedef struct packed {
		logic [3:0]        cmd;
		logic [TAG_W-1:0]  tag;
		logic [1:0]        priority_req;
		logic [CODE_W-1:0] command_code;
		logic [1:0]        sent_filter;
		logic [TMO_W-1:0]  timeout_secs;
		logic [TIME_W-1:0] now;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              found;
		logic [TAG_W-1:0]  entry_tag;
		logic [1:0]        entry_priority;
		logic [CODE_W-1:0] entry_command;
		logic              entry_sent;
		logic [LEN_W-1:0]  length;
		logic [LEN_W-1:0]  normal_length;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [1:0]        pri;
		logic [CODE_W-1:0] code;
		logic              sent;
		logic [TMO_W-1:0]  tmo;
		logic [TIME_W-1:0] stamp;
	} slot_t;

	// front -> back decoded request
	typedef struct packed {
		req_t             req;
		logic             auto_tag;
	} job_t;
endpackage

// File: hw/rtl/ppq_front.sv
// ----------------------------------------------------------------------------
// ppq_front: request intake
// Accepts requests, flags auto-tag requests, queues decoded jobs for the back end.
// ----------------------------------------------------------------------------
module ppq_front import ppq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic full,
	output logic empty,
	input  logic pop,
	output job_t job
);
	job_t                  fifo_q [QDEPTH];
	logic [0:0]            wr_q, rd_q;
	logic [1:0]            cnt_q;
	job_t                  jin;

	always_comb begin
		jin = '{req: req, auto_tag: (req.tag == '0)};
	end

	assign full  = (cnt_q == 2'(QDEPTH));
	assign empty = (cnt_q == 2'd0);
	assign job   = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (start && !full) begin
			fifo_q[wr_q] <= jin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (start && !full) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + 2'(start && !full) - 2'(pop);
		end
	end
endmodule

// File: hw/rtl/ppq_back.sv
// ----------------------------------------------------------------------------
// ppq_back: slot chain and command sequencer
// Holds the ordered entries, compares all slots at once, shifts to insert
// or remove, one result per cycle while the intake queue holds a job.
// ----------------------------------------------------------------------------
module ppq_back import ppq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  job_t job,
	output logic pop,
	output logic rsp_valid,
	output rsp_t rsp
);
	slot_t             slot_q [DEPTH];
	logic [LEN_W-1:0]  occ_q;
	logic [TAG_W-1:0]  ctr_q;
	logic              cancel_hit_q;
	logic              valid_q;
	rsp_t              rsp_q;

	logic [DEPTH-1:0]  live, hit_tag, hit_code, hit_tmo, imm;
	logic [IDX_W-1:0]  idx;
	logic              any;
	logic [LEN_W-1:0]  lead, ins_pos, lead_after;
	logic [TIME_W-1:0] diff;
	logic              do_rm, do_ins, do_mark, fin, fnd;
	logic [1:0]        st;
	slot_t             sel, nslot;
	logic [LEN_W-1:0]  occ_n;
	logic [DEPTH-1:0]  hit, imm_n;
	logic              nxt_ok;
	logic [LEN_W-1:0]  nxt_i;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			live[i]     = (LEN_W'(i) < occ_q);
			hit_tag[i]  = live[i] && slot_q[i].tag == job.req.tag;
			hit_code[i] = live[i] && slot_q[i].code == job.req.command_code
				&& !(job.req.sent_filter == FILT_WAIT && slot_q[i].sent)
				&& !(job.req.sent_filter == FILT_SENT && !slot_q[i].sent)
				|| (job.req.cmd == CMD_CANCEL && live[i]
					&& slot_q[i].code == job.req.command_code);
			diff        = job.req.now - slot_q[i].stamp;
			hit_tmo[i]  = live[i] && job.req.now >= slot_q[i].stamp
				&& diff >= TIME_W'(slot_q[i].tmo);
			imm[i]      = live[i] && slot_q[i].pri == PRI_IMM;
		end
		lead = '0;
		for (int i = DEPTH - 1; i >= 0; i--) if (!imm[i]) lead = LEN_W'(i);
		if (&imm) lead = LEN_W'(DEPTH);
		// no candidate when every slot is a sent immediate entry
		nxt_i = LEN_W'(DEPTH);
		for (int i = DEPTH - 1; i >= 0; i--)
			if (!(imm[i] && slot_q[i].sent)) nxt_i = LEN_W'(i);
		case (job.req.cmd)
			CMD_POP_HEAD: hit = {{(DEPTH-1){1'b0}}, live[0]};
			CMD_POP_TAG, CMD_FIND_TAG, CMD_MARK: hit = hit_tag;
			CMD_FIND_CMD, CMD_CANCEL: hit = hit_code;
			CMD_TIMEOUT: hit = hit_tmo;
			default: hit = '0;
		endcase
		any = |hit;
		idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) if (hit[i]) idx = IDX_W'(i);
		nxt_ok = 1'b0;
		if (job.req.cmd == CMD_NEXT) begin
			nxt_ok = (nxt_i < occ_q) && !slot_q[nxt_i[IDX_W-1:0]].sent;
			any = nxt_ok;
			idx = nxt_i[IDX_W-1:0];
		end

		nslot.tag  = job.auto_tag ? ctr_q : job.req.tag;
		nslot.pri  = job.req.priority_req;
		nslot.code = job.req.command_code;
		nslot.sent = 1'b0;
		nslot.tmo  = job.req.timeout_secs;
		nslot.stamp = job.req.now;
		ins_pos = (job.req.priority_req <= PRI_HIGH) ? lead : occ_q;

		do_ins = 1'b0; do_rm = 1'b0; do_mark = 1'b0; fin = 1'b1;
		st = ST_OK; fnd = any; sel = slot_q[idx];
		case (job.req.cmd)
			CMD_PUSH: begin
				if (occ_q == LEN_W'(DEPTH)) begin
					// rejected push echoes the tag as given
					st = ST_FULL; fnd = 1'b0; sel = nslot; sel.tag = job.req.tag;
				end else begin
					do_ins = 1'b1; fnd = 1'b1; sel = nslot;
				end
			end
			CMD_POP_HEAD, CMD_POP_TAG, CMD_TIMEOUT: do_rm = any;
			CMD_MARK: begin
				do_mark = any; sel.sent = 1'b1;
			end
			CMD_CANCEL: begin
				do_rm = any;
				fin = !(any && |(hit & ~(DEPTH'(1) << idx)));
			end
			CMD_FIND_TAG, CMD_FIND_CMD, CMD_NEXT: ;
			default: fnd = 1'b0;
		endcase
		occ_n = occ_q + LEN_W'(do_ins) - LEN_W'(do_rm);

		// leading immediate run after the operation
		for (int i = 0; i < DEPTH; i++) begin
			if (do_ins && LEN_W'(i) == ins_pos) imm_n[i] = nslot.pri == PRI_IMM;
			else if (do_ins && LEN_W'(i) > ins_pos) imm_n[i] = imm[i-1 < 0 ? 0 : i-1];
			else if (do_rm && i >= int'(idx))
				imm_n[i] = (i + 1 < DEPTH) ? imm[(i+1) % DEPTH] : 1'b0;
			else imm_n[i] = imm[i];
			if (LEN_W'(i) >= occ_n) imm_n[i] = 1'b0;
		end
		lead_after = LEN_W'(DEPTH);
		for (int i = DEPTH - 1; i >= 0; i--) if (!imm_n[i]) lead_after = LEN_W'(i);
		if (lead_after > occ_n) lead_after = occ_n;
		if (!fnd && job.req.cmd != CMD_PUSH) sel = '0;
		if (st == ST_FULL) sel.sent = 1'b0;
		// cancel with no match after earlier hits: no extra result
	end

	assign pop = !empty && fin;

	always_ff @(posedge clk) begin
		if (!empty) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (do_ins && LEN_W'(i) == ins_pos) slot_q[i] <= nslot;
				else if (do_ins && LEN_W'(i) > ins_pos) slot_q[i] <= slot_q[(i+DEPTH-1)%DEPTH];
				else if (do_rm && i >= int'(idx) && i + 1 < DEPTH)
					slot_q[i] <= slot_q[(i+1)%DEPTH];
				else if (do_mark && i == int'(idx)) slot_q[i].sent <= 1'b1;
			end
			rsp_q <= '{status: st, found: fnd, entry_tag: sel.tag,
				entry_priority: sel.pri, entry_command: sel.code,
				entry_sent: sel.sent, length: occ_n,
				normal_length: occ_n - lead_after, last: fin};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q        <= '0;
			ctr_q        <= '0;
			valid_q      <= 1'b0;
			cancel_hit_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			if (!empty) begin
				occ_q <= occ_n;
				if (do_ins && job.auto_tag) ctr_q <= ctr_q + 1'b1;
				// a cancel that already popped something ends on its last hit
				valid_q <= !(job.req.cmd == CMD_CANCEL && !any && cancel_hit_q);
				cancel_hit_q <= (job.req.cmd == CMD_CANCEL) && !fin;
			end
		end
	end

	assign rsp_valid = valid_q;
	assign rsp       = rsp_q;
endmodule

// File: hw/rtl/priority_pending_request_queue.sv
// ----------------------------------------------------------------------------
// priority_pending_request_queue: ordered queue of outstanding requests
// Push, pop, search, mark and cancel over a 16-entry priority-ordered queue.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: drive req and raise start; it is taken on a clock edge
//    where busy is low. busy is high while the two-entry intake queue is full.
//  - Result channel: each result shows on rsp for one cycle with done high;
//    the receiver cannot stall, so results are never held back.
//  - Path: an accepted request passes through the intake queue, then the
//    slot chain with registered output.
//  - Throughput: one result per cycle from the slot chain while a job is
//    queued; a cancel yields one result per entry it pops, any other command one.
//  - The slot chain compares all 16 slots in parallel and shifts the entries
//    from the insert or remove point by one place.
//  - Result last is high on the final result of a request.
//  - Reset empties the queue and zeroes the auto tag counter; slot contents
//    are left as they are and never read before written.
// ----------------------------------------------------------------------------
module priority_pending_request_queue import ppq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);
	logic empty, pop;
	job_t job;

	ppq_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.full(busy), .empty(empty), .pop(pop), .job(job)
	);

	// back end walks queued jobs one result per cycle
	ppq_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .job(job),
		.pop(pop), .rsp_valid(done), .rsp(rsp)
	);
endmodule

// File: hw/rtl/ppq_checker.sv
// ----------------------------------------------------------------------------
// ppq_checker: port-level checks
// Watches the top-level ports for result sanity.
// ----------------------------------------------------------------------------
module ppq_checker import ppq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic done,
	input rsp_t rsp
);
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.length <= LEN_W'(DEPTH)) else $error("length range");
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.normal_length <= rsp.length) else $error("normal length");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_FULL |-> rsp.length == LEN_W'(DEPTH) && rsp.last)
		else $error("full status");
endmodule

bind priority_pending_request_queue ppq_checker u_chk (
	.clk(clk), .arst_n(arst_n), .done(done), .rsp(rsp)
);

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the pending request queue
// Sends requests through the start/busy handshake and predicts every result
// with a behavioral copy of the slot chain. Each done-strobed result is
// compared field by field, in order, against the oldest expected result.
// ----------------------------------------------------------------------------
module tb;
	import ppq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	priority_pending_request_queue DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	// Behavioral copy of the queue.
	slot_t             shadow_slot [DEPTH];
	int                shadow_occ;
	logic [TAG_W-1:0]  shadow_tag_ctr;

	rsp_t exp_results [$];
	int   mismatches;
	int   idle_cycles;
	int   sender_idle_pct;
	logic [TIME_W-1:0] sim_now;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Length of the leading run of immediately entries.
	function automatic int lead_imm();
		int i;
		i = 0;
		while (i < shadow_occ && shadow_slot[i].pri == PRI_IMM)
			i++;
		return i;
	endfunction

	function automatic rsp_t make_result(logic [1:0] st, logic fnd, slot_t v);
		rsp_t r;
		r.status         = st;
		r.found          = fnd;
		r.entry_tag      = v.tag;
		r.entry_priority = v.pri;
		r.entry_command  = v.code;
		r.entry_sent     = v.sent;
		r.length         = LEN_W'(shadow_occ);
		r.normal_length  = LEN_W'(shadow_occ - lead_imm());
		r.last           = 1'b0;
		return r;
	endfunction

	function automatic void remove_slot(int idx);
		for (int j = idx; j + 1 < shadow_occ; j++)
			shadow_slot[j] = shadow_slot[j + 1];
		shadow_occ--;
	endfunction

	function automatic int find_by_tag(logic [TAG_W-1:0] t);
		for (int i = 0; i < shadow_occ; i++)
			if (shadow_slot[i].tag == t)
				return i;
		return -1;
	endfunction

	// Work out every result one request causes and queue them up.
	function automatic void predict_request(req_t r);
		rsp_t  res [$];
		slot_t v;
		slot_t none;
		int    idx;
		int    pos;
		int    i;
		none = '0;
		idx = -1;
		case (r.cmd)
			CMD_PUSH: begin
				if (shadow_occ >= DEPTH) begin
					v = '0;
					v.tag = r.tag;
					v.pri = r.priority_req;
					v.code = r.command_code;
					res.push_back(make_result(ST_FULL, 1'b0, v));
				end else begin
					v = '0;
					v.tag = r.tag;
					if (r.tag == '0) begin
						v.tag = shadow_tag_ctr;
						shadow_tag_ctr = shadow_tag_ctr + 1'b1;
					end
					v.pri   = r.priority_req;
					v.code  = r.command_code;
					v.sent  = 1'b0;
					v.tmo   = r.timeout_secs;
					v.stamp = r.now;
					pos = (r.priority_req <= PRI_HIGH) ? lead_imm() : shadow_occ;
					for (i = shadow_occ; i > pos; i--)
						shadow_slot[i] = shadow_slot[i - 1];
					shadow_slot[pos] = v;
					shadow_occ++;
					res.push_back(make_result(ST_OK, 1'b1, v));
				end
			end
			CMD_POP_HEAD, CMD_POP_TAG, CMD_FIND_TAG, CMD_MARK: begin
				if (r.cmd == CMD_POP_HEAD)
					idx = (shadow_occ > 0) ? 0 : -1;
				else
					idx = find_by_tag(r.tag);
				if (idx < 0) begin
					res.push_back(make_result(ST_OK, 1'b0, none));
				end else begin
					if (r.cmd == CMD_MARK)
						shadow_slot[idx].sent = 1'b1;
					v = shadow_slot[idx];
					if (r.cmd == CMD_POP_HEAD || r.cmd == CMD_POP_TAG)
						remove_slot(idx);
					res.push_back(make_result(ST_OK, 1'b1, v));
				end
			end
			CMD_FIND_CMD: begin
				for (i = 0; i < shadow_occ; i++) begin
					if (r.sent_filter == FILT_WAIT && shadow_slot[i].sent)
						continue;
					if (r.sent_filter == FILT_SENT && !shadow_slot[i].sent)
						continue;
					if (shadow_slot[i].code == r.command_code) begin
						idx = i;
						break;
					end
				end
				if (idx < 0)
					res.push_back(make_result(ST_OK, 1'b0, none));
				else
					res.push_back(make_result(ST_OK, 1'b1, shadow_slot[idx]));
			end
			CMD_NEXT: begin
				i = 0;
				while (i < shadow_occ && shadow_slot[i].pri == PRI_IMM && shadow_slot[i].sent)
					i++;
				if (i < shadow_occ && !shadow_slot[i].sent)
					res.push_back(make_result(ST_OK, 1'b1, shadow_slot[i]));
				else
					res.push_back(make_result(ST_OK, 1'b0, none));
			end
			CMD_TIMEOUT: begin
				// stamps in the future never count as expired
				for (i = 0; i < shadow_occ; i++) begin
					if (r.now >= shadow_slot[i].stamp &&
					    (r.now - shadow_slot[i].stamp) >= TIME_W'(shadow_slot[i].tmo)) begin
						idx = i;
						break;
					end
				end
				if (idx < 0) begin
					res.push_back(make_result(ST_OK, 1'b0, none));
				end else begin
					v = shadow_slot[idx];
					remove_slot(idx);
					res.push_back(make_result(ST_OK, 1'b1, v));
				end
			end
			CMD_CANCEL: begin
				// one result per popped entry, or one not-found result if none
				i = 0;
				while (i < shadow_occ) begin
					if (shadow_slot[i].code == r.command_code) begin
						v = shadow_slot[i];
						remove_slot(i);
						res.push_back(make_result(ST_OK, 1'b1, v));
					end else begin
						i++;
					end
				end
				if (res.size() == 0)
					res.push_back(make_result(ST_OK, 1'b0, none));
			end
			default: begin
				res.push_back(make_result(ST_OK, 1'b0, none));
			end
		endcase
		res[res.size() - 1].last = 1'b1;
		foreach (res[k])
			exp_results.push_back(res[k]);
	endfunction

	// Monitor: predict on acceptance, check each strobed result.
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if (done) begin
				if (exp_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %p", rsp);
				end else begin
					e = exp_results.pop_front();
					if (rsp.status !== e.status || rsp.found !== e.found ||
					    rsp.entry_tag !== e.entry_tag ||
					    rsp.entry_priority !== e.entry_priority ||
					    rsp.entry_command !== e.entry_command ||
					    rsp.entry_sent !== e.entry_sent ||
					    rsp.length !== e.length ||
					    rsp.normal_length !== e.normal_length ||
					    rsp.last !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p got %p", e, rsp);
					end
				end
			end
			if (start && !busy)
				predict_request(req);
		end
	end

	// Watchdog on cycles with no handshake activity at all.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Send one request; returns once it has been taken.
	task automatic send_request(req_t r);
		int gap;
		req   <= r;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			gap = $urandom_range(1, 8);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (exp_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic req_t build_req(logic [3:0] c, logic [TAG_W-1:0] t,
		logic [1:0] p, logic [CODE_W-1:0] code, logic [1:0] f,
		logic [TMO_W-1:0] tmo, logic [TIME_W-1:0] tnow);
		req_t r;
		r.cmd = c; r.tag = t; r.priority_req = p; r.command_code = code;
		r.sent_filter = f; r.timeout_secs = tmo; r.now = tnow;
		return r;
	endfunction

	// Random request with well-formed content most of the time.
	function automatic req_t random_req();
		req_t r;
		int   pick;
		r = '0;
		pick = $urandom_range(0, 99);
		if (pick < 40)      r.cmd = CMD_PUSH;
		else if (pick < 47) r.cmd = CMD_POP_HEAD;
		else if (pick < 54) r.cmd = CMD_POP_TAG;
		else if (pick < 61) r.cmd = CMD_FIND_TAG;
		else if (pick < 68) r.cmd = CMD_FIND_CMD;
		else if (pick < 75) r.cmd = CMD_NEXT;
		else if (pick < 84) r.cmd = CMD_MARK;
		else if (pick < 91) r.cmd = CMD_TIMEOUT;
		else if (pick < 97) r.cmd = CMD_CANCEL;
		else                r.cmd = 4'($urandom_range(9, 15));
		// small tag pool so lookups hit; zero for auto tags
		pick = $urandom_range(0, 9);
		if (pick < 2)      r.tag = '0;
		else if (pick < 8) r.tag = TAG_W'($urandom_range(1, 8));
		else               r.tag = TAG_W'($urandom());
		r.priority_req = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 9) < 8)
			r.command_code = CODE_W'($urandom_range(1, 4));
		else
			r.command_code = CODE_W'($urandom());
		r.sent_filter = 2'($urandom_range(0, 3));
		pick = $urandom_range(0, 19);
		if (pick == 0)      r.timeout_secs = '1;
		else if (pick == 1) r.timeout_secs = TMO_W'($urandom());
		else                r.timeout_secs = TMO_W'($urandom_range(0, 6));
		sim_now = sim_now + TIME_W'($urandom_range(0, 3));
		if ($urandom_range(0, 19) == 0)
			r.now = $urandom();
		else
			r.now = sim_now;
		return r;
	endfunction

	task automatic test_directed();
		// fill past full with mixed priorities, first two auto tagged
		send_request(build_req(CMD_PUSH, '0, 2'd2, 16'h0001, 2'd0, 16'd0, 32'd0));
		send_request(build_req(CMD_PUSH, '0, 2'd0, 16'h0002, 2'd0, 16'd5, 32'd0));
		send_request(build_req(CMD_PUSH, 16'hFFFF, 2'd1, 16'hFFFF, 2'd0, 16'hFFFF,
			32'hFFFF_FFFF));
		send_request(build_req(CMD_PUSH, 16'd7, 2'd3, 16'h0001, 2'd0, 16'd2, 32'd10));
		for (int i = 0; i < 13; i++)
			send_request(build_req(CMD_PUSH, TAG_W'(i + 20), 2'(i), 16'h0003, 2'd0,
				16'd1, 32'd20));
		send_request(build_req(CMD_MARK, 16'd7, 2'd0, 16'd0, 2'd0, 16'd0, 32'd0));
		send_request(build_req(CMD_FIND_CMD, 16'd0, 2'd0, 16'h0001, FILT_SENT, 16'd0, 32'd0));
		send_request(build_req(CMD_FIND_CMD, 16'd0, 2'd0, 16'h0001, FILT_WAIT, 16'd0, 32'd0));
		send_request(build_req(CMD_FIND_CMD, 16'd0, 2'd0, 16'h0001, 2'd3, 16'd0, 32'd0));
		send_request(build_req(CMD_NEXT, 16'd0, 2'd0, 16'd0, 2'd0, 16'd0, 32'd0));
		send_request(build_req(CMD_TIMEOUT, 16'd0, 2'd0, 16'd0, 2'd0, 16'd0, 32'd3));
		send_request(build_req(CMD_FIND_TAG, 16'hFFFF, 2'd0, 16'd0, 2'd0, 16'd0, 32'd0));
		send_request(build_req(CMD_POP_TAG, 16'hFFFF, 2'd0, 16'd0, 2'd0, 16'd0, 32'd0));
		send_request(build_req(CMD_CANCEL, 16'd0, 2'd0, 16'h0003, 2'd0, 16'd0, 32'd0));
		send_request(build_req(CMD_CANCEL, 16'd0, 2'd0, 16'h0003, 2'd0, 16'd0, 32'd0));
		send_request(build_req(CMD_POP_HEAD, 16'd0, 2'd0, 16'd0, 2'd0, 16'd0, 32'd0));
		send_request(build_req(4'hF, 16'd0, 2'd0, 16'd0, 2'd0, 16'd0, 32'd0));
		wait_drained();
	endtask

	task automatic test_random(int n, int idle_pct);
		sender_idle_pct = idle_pct;
		for (int i = 0; i < n; i++)
			send_request(random_req());
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		shadow_occ = 0;
		shadow_tag_ctr = '0;
		mismatches = 0;
		idle_cycles = 0;
		sender_idle_pct = 0;
		sim_now = '0;
		foreach (shadow_slot[i])
			shadow_slot[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(140, 10);
		test_random(140, 45);
		test_random(140, 0);

		if (mismatches == 0 && exp_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
